/* rtl/mf3x3_pkg.sv */
package mf3x3_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 2;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4095;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef logic [PIX_W-1:0] t_pix;

    // One column of the 3x3 window: top is two rows up, bot is the newest row.
    typedef struct packed {
        t_pix bot;
        t_pix mid;
        t_pix top;
    } t_wcol;

    // Index 0 is the oldest column, index 2 the newest.
    typedef t_wcol [2:0] t_win;

    // Edge replication choice for one result.
    typedef struct packed {
        logic row_last;
        logic col_last;
    } t_msel;

endpackage

/* rtl/median_filter_3x3_unit.sv */
// 3x3 median filter over a raster-order stream of 8-bit pixels.
// Pixels enter on the input channel (i_in_valid, o_in_stall, i_pixel_value)
// in raster order for a frame of the configured width and height; edge
// pixels are replicated. Results leave on the output channel (o_out_valid,
// i_out_stall and the result fields), each with its centre coordinates,
// a flag on the last result caused by a pixel and a flag on the frame's
// final result. Results trail the input by one row and one column.
// The configuration channel writes image_width (index 0) and image_height
// (index 1); it is always ready and should be used only while idle.
// The first result of a pixel passes through stage 1, stage 2 and the
// output register. Throughput: one pixel per cycle while the output is not
// stalled and each pixel yields at most one result; a pixel with more than
// one result (up to four, at the right edge and on the last row) holds the
// input and issues one result per cycle while the output is not stalled.
// A stall on the output holds the output register and fills the two internal
// stages behind it, after which o_in_stall rises.
// Reset clears the position counters and the pipeline and sets the size to
// 640 x 480. The line stores are not cleared: each entry is written in a
// row before it is read in the next one.
module median_filter_3x3_unit #(
    parameter int MAX_WIDTH  = mf3x3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf3x3_pkg::MAX_HEIGHT_DEF,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mf3x3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mf3x3_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mf3x3_pkg::t_pix                  i_pixel_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mf3x3_pkg::t_pix                  o_median_value,
    output logic [RW-1:0]                    o_out_row,
    output logic [CW-1:0]                    o_out_col,
    output logic                             o_last_of_run,
    output logic                             o_frame_done
);

    import mf3x3_pkg::*;

    localparam int WB_W  = $clog2(MAX_WIDTH + 1);
    localparam int HB_W  = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_A = (WB_W > HB_W) ? WB_W : HB_W;
    localparam int CMP_W = (CMP_A > CFG_W) ? CMP_A : CFG_W;

    // Result slots of one pixel, in the order they leave.
    localparam int EMIT_PP = 0;  // previous row, previous column
    localparam int EMIT_PL = 1;  // previous row, last column
    localparam int EMIT_LP = 2;  // last row, previous column
    localparam int EMIT_LL = 3;  // last row, last column

    // Configuration
    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic [CMP_W-1:0] w_lim;
    logic [CMP_W-1:0] h_lim;
    logic [CW-1:0]    w_m1;
    logic [RW-1:0]    h_m1;

    // Position counters and the pixel being accepted
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] c_col;
    logic [RW-1:0] c_row;
    logic          c_last_col;
    logic          c_last_row;
    logic          accept;

    // Stage 1: line store reads in flight
    logic          r_s1_valid;
    t_pix          r_s1_pix;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_last_col;
    logic          r_s1_last_row;
    t_pix          ram_rd [2];
    t_pix          up1;
    t_pix          up2;
    t_wcol         new_col;
    t_win          n_win;
    logic [3:0]    n_s2_pend;

    // Stage 2: window and pending results
    t_win          r_win;
    logic [3:0]    r_s2_pend;
    logic [CW-1:0] r_s2_col;
    logic [RW-1:0] r_s2_row;
    logic          r_s2_frame;
    logic [3:0]    pick;
    logic [3:0]    rem;
    t_msel         sel;
    t_pix          med;

    // Output register
    logic          r_out_valid;
    t_pix          r_out_med;
    logic [RW-1:0] r_out_row;
    logic [CW-1:0] r_out_col;
    logic          r_out_last;
    logic          r_out_frame;

    // Flow control
    logic out_free;
    logic emit;
    logic s2_free;
    logic s1_adv;
    logic s1_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A size of zero acts as one, a size above the maximum as the maximum.
    always_comb begin
        w_lim = CMP_W'(r_cfg_width);
        if (w_lim == '0) begin
            w_lim = CMP_W'(1);
        end else if (w_lim > CMP_W'(MAX_WIDTH)) begin
            w_lim = CMP_W'(MAX_WIDTH);
        end
        h_lim = CMP_W'(r_cfg_height);
        if (h_lim == '0) begin
            h_lim = CMP_W'(1);
        end else if (h_lim > CMP_W'(MAX_HEIGHT)) begin
            h_lim = CMP_W'(MAX_HEIGHT);
        end
    end

    assign w_m1 = CW'(w_lim - CMP_W'(1));
    assign h_m1 = RW'(h_lim - CMP_W'(1));

    // After a size change mid-frame the position saturates at the new edge.
    assign c_col      = (r_col > w_m1) ? w_m1 : r_col;
    assign c_row      = (r_row > h_m1) ? h_m1 : r_row;
    assign c_last_col = (c_col == w_m1);
    assign c_last_row = (c_row == h_m1);

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = (r_s2_pend != 4'd0) && out_free;
    assign pick     = r_s2_pend & (~r_s2_pend + 4'd1);
    assign rem      = r_s2_pend & (r_s2_pend - 4'd1);
    assign s2_free  = (r_s2_pend == 4'd0) || (out_free && (rem == 4'd0));
    assign s1_adv   = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign accept   = i_in_valid && s1_free;

    assign o_in_stall = !s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (c_last_col) begin
                r_col <= '0;
                r_row <= c_last_row ? '0 : RW'(c_row + RW'(1));
            end else begin
                r_col <= CW'(c_col + CW'(1));
                r_row <= c_row;
            end
        end
    end

    // Two line stores, one per row parity. The store of the current parity
    // holds the row two above and is overwritten with the arriving pixel.
    for (genvar g = 0; g < 2; g++) begin : g_line
        mf3x3_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (accept && (c_row[0] == 1'(g))),
            .i_waddr (c_col),
            .i_wdata (i_pixel_value),
            .i_re    (accept),
            .i_raddr (c_col),
            .o_rdata (ram_rd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= i_pixel_value;
            r_s1_col      <= c_col;
            r_s1_row      <= c_row;
            r_s1_last_col <= c_last_col;
            r_s1_last_row <= c_last_row;
        end
    end

    // Rows above the top of the frame repeat the arriving top row.
    always_comb begin
        up1 = r_s1_pix;
        if (r_s1_row != '0) begin
            up1 = r_s1_row[0] ? ram_rd[0] : ram_rd[1];
        end
        up2 = up1;
        if (r_s1_row > RW'(1)) begin
            up2 = r_s1_row[0] ? ram_rd[1] : ram_rd[0];
        end
        new_col = '{top: up2, mid: up1, bot: r_s1_pix};
        if (r_s1_col == '0) begin
            n_win = {new_col, new_col, new_col};
        end else begin
            n_win = {new_col, r_win[2], r_win[1]};
        end
        n_s2_pend          = 4'd0;
        n_s2_pend[EMIT_PP] = (r_s1_row != '0) && (r_s1_col != '0);
        n_s2_pend[EMIT_PL] = (r_s1_row != '0) && r_s1_last_col;
        n_s2_pend[EMIT_LP] = r_s1_last_row && (r_s1_col != '0);
        n_s2_pend[EMIT_LL] = r_s1_last_row && r_s1_last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_pend <= 4'd0;
        end else if (s1_adv) begin
            r_s2_pend <= n_s2_pend;
        end else if (emit) begin
            r_s2_pend <= rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_win      <= n_win;
            r_s2_col   <= r_s1_col;
            r_s2_row   <= r_s1_row;
            r_s2_frame <= r_s1_last_row && r_s1_last_col;
        end
    end

    assign sel.row_last = pick[EMIT_LP] || pick[EMIT_LL];
    assign sel.col_last = pick[EMIT_PL] || pick[EMIT_LL];

    mf3x3_median u_median (
        .i_win    (r_win),
        .i_sel    (sel),
        .o_median (med)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_med   <= med;
            r_out_row   <= sel.row_last ? r_s2_row : RW'(r_s2_row - RW'(1));
            r_out_col   <= sel.col_last ? r_s2_col : CW'(r_s2_col - CW'(1));
            r_out_last  <= (rem == 4'd0);
            r_out_frame <= (rem == 4'd0) && r_s2_frame;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_median_value = r_out_med;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_last_of_run  = r_out_last;
    assign o_frame_done   = r_out_frame;

endmodule

/* rtl/mf3x3_ram.sv */
module mf3x3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // A read and a write to the same address in one cycle return the old contents.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mf3x3_median.sv */
module mf3x3_median (
    input  mf3x3_pkg::t_win  i_win,
    input  mf3x3_pkg::t_msel i_sel,
    output mf3x3_pkg::t_pix  o_median
);

    import mf3x3_pkg::*;

    t_pix s [9];

    // Tap k of three, with the last tap repeated at the bottom or right edge.
    function automatic logic [1:0] tap_idx(input logic [1:0] k, input logic last);
        logic [1:0] idx;
        idx = k;
        if (last) begin
            idx = (k == 2'd0) ? 2'd1 : 2'd2;
        end
        return idx;
    endfunction

    function automatic t_pix pick(input t_wcol col, input logic [1:0] idx);
        t_pix v;
        unique case (idx)
            2'd0:    v = col.top;
            2'd1:    v = col.mid;
            default: v = col.bot;
        endcase
        return v;
    endfunction

    // Compare and exchange: the smaller value goes to the first place.
    function automatic logic [2*PIX_W-1:0] cas(input t_pix a, input t_pix b);
        return (a > b) ? {b, a} : {a, b};
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s[i*3+j] = pick(i_win[tap_idx(2'(j), i_sel.col_last)],
                                tap_idx(2'(i), i_sel.row_last));
            end
        end

        // Nineteen-exchange median network; the middle value ends in place four.
        {s[1], s[2]} = cas(s[1], s[2]);
        {s[4], s[5]} = cas(s[4], s[5]);
        {s[7], s[8]} = cas(s[7], s[8]);
        {s[0], s[1]} = cas(s[0], s[1]);
        {s[3], s[4]} = cas(s[3], s[4]);
        {s[6], s[7]} = cas(s[6], s[7]);
        {s[1], s[2]} = cas(s[1], s[2]);
        {s[4], s[5]} = cas(s[4], s[5]);
        {s[7], s[8]} = cas(s[7], s[8]);
        {s[0], s[3]} = cas(s[0], s[3]);
        {s[5], s[8]} = cas(s[5], s[8]);
        {s[4], s[7]} = cas(s[4], s[7]);
        {s[3], s[6]} = cas(s[3], s[6]);
        {s[1], s[4]} = cas(s[1], s[4]);
        {s[2], s[5]} = cas(s[2], s[5]);
        {s[4], s[7]} = cas(s[4], s[7]);
        {s[4], s[2]} = cas(s[4], s[2]);
        {s[6], s[4]} = cas(s[6], s[4]);
        {s[4], s[2]} = cas(s[4], s[2]);
        o_median = s[4];
    end

endmodule

/* tb/tb_median_filter_3x3_unit.sv */
`timescale 1ns / 100ps

module tb_median_filter_3x3_unit;
    import mf3x3_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum int {PIX_UNIFORM, PIX_SALT_PEPPER, PIX_NEAR_FLAT} t_pix_style;

    typedef struct {
        t_pix        median;
        logic [11:0] row;
        logic [10:0] col;
        logic        last;
        logic        done;
    } t_med_result;

    class median_checker;
        t_pix        line_mem [2][MAX_WIDTH_DEF];
        t_win        win;
        int          col_pos;
        int          row_pos;
        logic [11:0] width_reg;
        logic [11:0] height_reg;
        t_med_result pending_medians [$];
        int          mismatch_count;

        function new();
            foreach (line_mem[p, c]) line_mem[p][c] = '0;
            win            = '0;
            col_pos        = 0;
            row_pos        = 0;
            width_reg      = WIDTH_RST;
            height_reg     = HEIGHT_RST;
            mismatch_count = 0;
        endfunction

        task report_mismatch(input string what);
            if (mismatch_count < 50) begin
                $display("%0t ns: mismatch: %s", $realtime, what);
            end
            mismatch_count++;
        endtask

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH: begin
                    width_reg = val;
                end
                CFG_IMAGE_HEIGHT: begin
                    height_reg = val;
                end
                default: begin
                end
            endcase
        endfunction

        // ri: 0 is two rows up, 1 the row above, 2 the newest row.
        function t_pix window_at(input int ci, input int ri);
            t_wcol wc;
            wc = win[ci];
            case (ri)
                0: return wc.top;
                1: return wc.mid;
                default: return wc.bot;
            endcase
        endfunction

        // The fifth smallest is the value with at most four strictly below
        // it and at least five at or below it.
        function t_pix rank_five(input t_pix v [9]);
            int below;
            int at_or_below;
            for (int i = 0; i < 9; i++) begin
                below       = 0;
                at_or_below = 0;
                for (int j = 0; j < 9; j++) begin
                    if (v[j] < v[i]) below++;
                    if (v[j] <= v[i]) at_or_below++;
                end
                if (below <= 4 && at_or_below >= 5) return v[i];
            end
            return v[4];
        endfunction

        function t_med_result neighbourhood_median(input bit row_edge, input bit col_edge,
                                                   input int orow, input int ocol);
            t_pix        v [9];
            int          rsel [3];
            int          csel [3];
            t_med_result res;
            for (int i = 0; i < 3; i++) begin
                rsel[i] = row_edge ? ((i == 0) ? 1 : 2) : i;
                csel[i] = col_edge ? ((i == 0) ? 1 : 2) : i;
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    v[i * 3 + j] = window_at(csel[j], rsel[i]);
                end
            end
            res.median = rank_five(v);
            res.row    = orow[11:0];
            res.col    = ocol[10:0];
            res.last   = 1'b0;
            res.done   = 1'b0;
            return res;
        endfunction

        function void take_pixel(input t_pix px);
            int          w;
            int          h;
            int          c;
            int          r;
            bit          lc;
            bit          lr;
            t_pix        up1;
            t_pix        up2;
            t_wcol       fresh;
            int          n;
            bit          row_sel [4];
            bit          col_sel [4];
            int          orow [4];
            int          ocol [4];
            t_med_result res;

            w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF
                                                                    : int'(width_reg));
            h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF
                                                                      : int'(height_reg));
            c  = (col_pos > w - 1) ? w - 1 : col_pos;
            r  = (row_pos > h - 1) ? h - 1 : row_pos;
            lc = (c == w - 1);
            lr = (r == h - 1);

            // The top rows of the frame take the arriving pixel in place of
            // the line store.
            up1 = (r >= 1) ? line_mem[(r + 1) % 2][c] : px;
            up2 = (r >= 2) ? line_mem[r % 2][c] : up1;
            fresh.top = up2;
            fresh.mid = up1;
            fresh.bot = px;
            if (c == 0) begin
                win = {fresh, fresh, fresh};
            end else begin
                win[0] = win[1];
                win[1] = win[2];
                win[2] = fresh;
            end
            line_mem[r % 2][c] = px;

            n = 0;
            for (int pass = 0; pass < 2; pass++) begin
                if ((pass == 0 && r >= 1) || (pass == 1 && lr)) begin
                    if (c >= 1) begin
                        row_sel[n] = (pass == 1);
                        col_sel[n] = 1'b0;
                        orow[n]    = (pass == 0) ? r - 1 : r;
                        ocol[n]    = c - 1;
                        n++;
                    end
                    if (lc) begin
                        row_sel[n] = (pass == 1);
                        col_sel[n] = 1'b1;
                        orow[n]    = (pass == 0) ? r - 1 : r;
                        ocol[n]    = c;
                        n++;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                res      = neighbourhood_median(row_sel[k], col_sel[k], orow[k], ocol[k]);
                res.last = (k == n - 1);
                res.done = (k == n - 1) && lr && lc;
                pending_medians.insert(pending_medians.size(), res);
            end

            if (lc) begin
                col_pos = 0;
                row_pos = lr ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        task match_result(input t_med_result got);
            t_med_result want;
            if (pending_medians.size() == 0) begin
                report_mismatch($sformatf("result at row %0d col %0d with nothing expected",
                                          got.row, got.col));
                return;
            end
            want = pending_medians.pop_front();
            if (got.median !== want.median)
                report_mismatch($sformatf("median %0d, expected %0d (row %0d col %0d)",
                                          got.median, want.median, want.row, want.col));
            if (got.row !== want.row)
                report_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
            if (got.col !== want.col)
                report_mismatch($sformatf("col %0d, expected %0d", got.col, want.col));
            if (got.last !== want.last)
                report_mismatch($sformatf("last_of_run %b, expected %b (row %0d col %0d)",
                                          got.last, want.last, want.row, want.col));
            if (got.done !== want.done)
                report_mismatch($sformatf("frame_done %b, expected %b (row %0d col %0d)",
                                          got.done, want.done, want.row, want.col));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_pix                 i_pixel_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_pix                 o_median_value;
    logic [11:0]          o_out_row;
    logic [10:0]          o_out_col;
    logic                 o_last_of_run;
    logic                 o_frame_done;

    median_checker sb;
    int            send_pct = 0;
    int            stall_pct = 0;
    int            cycle_count = 0;

    t_pix corner_px [9] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h7F};

    median_filter_3x3_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_value  (i_pixel_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_median_value (o_median_value),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_last_of_run  (o_last_of_run),
        .o_frame_done   (o_frame_done)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Values are sampled as they stood before the edge, so every transfer
    // seen here is the one the block saw.
    always @(posedge i_clk) begin
        t_med_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) sb.take_pixel(i_pixel_value);
            if (o_out_valid && !i_out_stall) begin
                got.median = o_median_value;
                got.row    = o_out_row;
                got.col    = o_out_col;
                got.last   = o_last_of_run;
                got.done   = o_frame_done;
                sb.match_result(got);
            end
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_pct  = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_pct  = 77;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_pct  = 0;
                stall_pct = 77;
            end
            default: begin
                send_pct  = 37;
                stall_pct = 37;
            end
        endcase
    endtask

    // Valid is left high after a transfer so that back-to-back pixels
    // need no extra assignment; it is lowered on a gap or when draining.
    task automatic send_pixel(input t_pix px);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_value <= px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_medians.size() != 0) @(posedge i_clk);
        // A pixel with no result may still be in flight.
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_pix next_pixel(input t_pix_style style);
        case (style)
            PIX_SALT_PEPPER: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            PIX_NEAR_FLAT:   return t_pix'(120 + $urandom_range(7));
            default:         return t_pix'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int random_items;
        int w;
        int h;
        int frame_no;

        sb = new();
        set_idling(IDLE_NONE);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 frame: top row, corners and the four-result last pixel.
        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        write_reg(CFG_IMAGE_HEIGHT, 12'd3);
        foreach (corner_px[i]) send_pixel(corner_px[i]);

        // Zero width acts as one column, zero height as one row.
        set_idling(IDLE_RECEIVER);
        write_reg(CFG_IMAGE_WIDTH, 12'd0);
        write_reg(CFG_IMAGE_HEIGHT, 12'd3);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h80);
        write_reg(CFG_IMAGE_WIDTH, 12'd1);
        write_reg(CFG_IMAGE_HEIGHT, 12'd0);
        send_pixel(8'h55);
        write_reg(REG_UNUSED, 12'hABC);

        // Shrinking mid-frame saturates the position to the last row and column.
        set_idling(IDLE_SENDER);
        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        write_reg(CFG_IMAGE_HEIGHT, 12'd4);
        for (int i = 0; i < 7; i++) send_pixel(next_pixel(PIX_UNIFORM));
        write_reg(CFG_IMAGE_WIDTH, 12'd2);
        write_reg(CFG_IMAGE_HEIGHT, 12'd2);
        send_pixel(8'hAA);

        // Widest and tallest settings, then a shrink to finish the frame.
        set_idling(IDLE_BOTH);
        write_reg(CFG_IMAGE_WIDTH, 12'hFFF);
        write_reg(CFG_IMAGE_HEIGHT, 12'hFFF);
        send_pixel(8'h10);
        send_pixel(8'hEF);
        write_reg(CFG_IMAGE_WIDTH, 12'd2048);
        send_pixel(8'h33);
        write_reg(CFG_IMAGE_WIDTH, 12'd2);
        send_pixel(8'hC4);
        write_reg(CFG_IMAGE_HEIGHT, 12'd2);
        send_pixel(8'h01);
        send_pixel(8'hFE);

        random_items = 0;
        frame_no     = 0;
        while (random_items < 170) begin
            set_idling(t_idle_mode'(frame_no % 4));
            if ($urandom_range(5) == 0) begin
                w = $urandom_range(9, 40);
                h = $urandom_range(1, 3);
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
            end
            write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
            write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
            repeat (w * h) send_pixel(next_pixel(t_pix_style'($urandom_range(2))));
            random_items += w * h;
            frame_no++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
